[hw/rtl/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg: shared types and codes of the sorted id table
// Operation and status codes, the cell command set and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

   // table size default and fixed field widths
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int ID_W            = 32;
   localparam int HND_W           = 16;
   localparam int FUNC_W          = 2;
   localparam int STAT_W          = 2;

   // operation codes on req_func
   localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

   // status codes on rsp_status
   localparam logic [STAT_W-1:0] STS_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STS_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STS_MISS = 2'd2;

   // command broadcast to every cell
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_WRITE,
      OP_ROT_L,
      OP_ROT_R,
      OP_SORT,
      OP_DROP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        parity;
   } cell_ctl_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT,
      ST_SEEK,
      ST_BACK,
      ST_SCAN,
      ST_DROP
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/sit_cell.sv]
// ----------------------------------------------------------------------------
// sit_cell: one entry of the table chain
// Holds one (id, handle) entry and loads it from its neighbors, from the
// request or keeps it, as the broadcast command says.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_cell #(
   parameter int DEPTH = sit_pkg::TABLE_DEPTH_DEF,
   parameter int IDX   = 0,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  sit_pkg::cell_ctl_type            cell_ctl,
   input  logic [CW-1:0]                    cell_sel,
   input  logic [CW-1:0]                    cell_count,
   input  logic signed [sit_pkg::ID_W-1:0]  key_id,
   input  logic [sit_pkg::HND_W-1:0]        key_hnd,
   input  logic signed [sit_pkg::ID_W-1:0]  left_id,
   input  logic [sit_pkg::HND_W-1:0]        left_hnd,
   input  logic signed [sit_pkg::ID_W-1:0]  right_id,
   input  logic [sit_pkg::HND_W-1:0]        right_hnd,
   input  logic                             swap_in,
   output logic signed [sit_pkg::ID_W-1:0]  id_q,
   output logic [sit_pkg::HND_W-1:0]        hnd_q,
   output logic                             swap_out
);
   import sit_pkg::*;

   localparam logic [CW:0] POS       = (CW + 1)'(IDX);
   localparam logic [CW:0] NEXT_POS  = (CW + 1)'(IDX + 1);
   localparam bit          HAS_RIGHT = (IDX < DEPTH - 1);

   logic signed [ID_W-1:0] id_ff, id_in;
   logic [HND_W-1:0]       hnd_ff, hnd_in;
   logic                   pair_live;
   logic                   at_sel;
   logic                   past_sel;

   // this cell and its right neighbor form a live pair in this sort phase
   assign pair_live = HAS_RIGHT && (POS[0] == cell_ctl.parity)
                      && (NEXT_POS < {1'b0, cell_count});
   assign swap_out  = (cell_ctl.op == OP_SORT) && pair_live && (id_ff > right_id);
   assign at_sel    = (POS == {1'b0, cell_sel});
   assign past_sel  = (POS >= {1'b0, cell_sel});

   // next entry
   always_comb begin
      id_in  = id_ff;
      hnd_in = hnd_ff;
      unique case (cell_ctl.op)
         OP_HOLD: begin
         end
         OP_WRITE: begin
            if (at_sel) begin
               id_in  = key_id;
               hnd_in = key_hnd;
            end
         end
         OP_ROT_L: begin
            id_in  = right_id;
            hnd_in = right_hnd;
         end
         OP_ROT_R: begin
            id_in  = left_id;
            hnd_in = left_hnd;
         end
         OP_SORT: begin
            if (swap_out) begin
               id_in  = right_id;
               hnd_in = right_hnd;
            end else if (swap_in) begin
               id_in  = left_id;
               hnd_in = left_hnd;
            end
         end
         OP_DROP: begin
            if (past_sel) begin
               id_in  = right_id;
               hnd_in = right_hnd;
            end
         end
         default: begin
         end
      endcase
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      hnd_ff <= hnd_in;
   end

   assign id_q  = id_ff;
   assign hnd_q = hnd_ff;

endmodule

`default_nettype wire

[hw/rtl/sit_ctrl.sv]
// ----------------------------------------------------------------------------
// sit_ctrl: sequencer of the sorted id table
// Runs insert, sort, binary search and remove by issuing cell commands and
// watching the head cell; keeps count, sort flag, ring offset and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_ctrl #(
   parameter int DEPTH = sit_pkg::TABLE_DEPTH_DEF,
   localparam int CW   = $clog2(DEPTH + 1),
   localparam int IW   = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sit_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [sit_pkg::ID_W-1:0]  req_key_id,
   input  logic [sit_pkg::HND_W-1:0]        req_obj_handle,
   input  logic signed [sit_pkg::ID_W-1:0]  head_id,
   input  logic [sit_pkg::HND_W-1:0]        head_hnd,
   output sit_pkg::cell_ctl_type            cell_ctl,
   output logic [CW-1:0]                    cell_sel,
   output logic [CW-1:0]                    cell_count,
   output logic                             rsp_strobe,
   output logic [sit_pkg::STAT_W-1:0]       rsp_status,
   output logic [sit_pkg::HND_W-1:0]        rsp_found_handle
);
   import sit_pkg::*;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   needs_sort_ff, needs_sort_in;
   logic [IW-1:0]          offset_ff, offset_in;
   logic signed [ID_W-1:0] key_ff, key_in;
   logic [HND_W-1:0]       hnd_ff, hnd_in;
   logic [CW-1:0]          first_ff, first_in;
   logic [CW-1:0]          last1_ff, last1_in;
   logic [CW-1:0]          round_ff, round_in;
   logic [IW-1:0]          mark_ff, mark_in;
   logic                   hit_ff, hit_in;
   logic [STAT_W-1:0]      res_status_ff, res_status_in;
   logic [HND_W-1:0]       res_found_ff, res_found_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [HND_W-1:0]       rsp_found_ff, rsp_found_in;

   logic                   accept;
   logic                   is_full;
   logic [CW:0]            mid_sum;
   logic [IW-1:0]          mid_idx;
   logic                   at_mid;
   logic                   range_empty;
   logic                   key_eq;
   logic                   key_gt;
   logic                   seek_done;
   logic                   offset_last;
   logic                   scan_hit;
   logic                   sort_last;

   // helpers
   assign accept      = start && (state_ff == ST_IDLE);
   assign is_full     = (count_ff == CW'(DEPTH));
   assign mid_sum     = {1'b0, first_ff} + {1'b0, last1_ff} - (CW + 1)'(1);
   assign mid_idx     = mid_sum[IW:1];
   assign at_mid      = (offset_ff == mid_idx);
   assign range_empty = (first_ff >= last1_ff);
   assign key_eq      = (key_ff == head_id);
   assign key_gt      = (key_ff > head_id);
   assign seek_done   = range_empty || (at_mid && key_eq);
   assign offset_last = (offset_ff == IW'(DEPTH - 1));
   assign scan_hit    = !hit_ff && (CW'(offset_ff) < count_ff) && (head_hnd == hnd_ff);
   assign sort_last   = (({1'b0, round_ff} + (CW + 1)'(1)) >= {1'b0, count_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FN_SEARCH) begin
                  state_in = needs_sort_ff ? ST_SORT : ST_SEEK;
               end else if (req_func == FN_REMOVE) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SORT: begin
            if (sort_last) begin
               state_in = ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (seek_done) begin
               state_in = (offset_ff == '0) ? ST_IDLE : ST_BACK;
            end
         end
         ST_BACK: begin
            if (offset_ff == IW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (offset_last) begin
               state_in = (hit_ff || scan_hit) ? ST_DROP : ST_IDLE;
            end
         end
         ST_DROP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cell commands, datapath updates and result
   always_comb begin
      cell_ctl.op     = OP_HOLD;
      cell_ctl.parity = round_ff[0];
      cell_sel        = count_ff;
      count_in        = count_ff;
      needs_sort_in   = needs_sort_ff;
      offset_in       = offset_ff;
      key_in          = key_ff;
      hnd_in          = hnd_ff;
      first_in        = first_ff;
      last1_in        = last1_ff;
      round_in        = round_ff;
      mark_in         = mark_ff;
      hit_in          = hit_ff;
      res_status_in   = res_status_ff;
      res_found_in    = res_found_ff;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = req_key_id;
               hnd_in   = req_obj_handle;
               first_in = '0;
               last1_in = count_ff;
               round_in = '0;
               hit_in   = 1'b0;
               unique case (req_func)
                  FN_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     rsp_found_in  = '0;
                     if (is_full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        cell_ctl.op   = OP_WRITE;
                        count_in      = count_ff + CW'(1);
                        needs_sort_in = 1'b1;
                        rsp_status_in = STS_OK;
                     end
                  end
                  FN_SEARCH, FN_REMOVE: begin
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STS_MISS;
                     rsp_found_in  = '0;
                  end
               endcase
            end
         end
         // odd-even transposition rounds
         ST_SORT: begin
            cell_ctl.op = OP_SORT;
            round_in    = round_ff + CW'(1);
            if (sort_last) begin
               needs_sort_in = 1'b0;
            end
         end
         // binary search, rotating the ring until mid sits at the head
         ST_SEEK: begin
            if (seek_done) begin
               res_status_in = range_empty ? STS_MISS : STS_OK;
               res_found_in  = range_empty ? '0 : head_hnd;
               if (offset_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = range_empty ? STS_MISS : STS_OK;
                  rsp_found_in  = range_empty ? '0 : head_hnd;
               end
            end else if (at_mid) begin
               if (key_gt) begin
                  first_in = CW'(mid_idx) + CW'(1);
               end else begin
                  last1_in = CW'(mid_idx);
               end
            end else if (mid_idx > offset_ff) begin
               cell_ctl.op = OP_ROT_L;
               offset_in   = offset_ff + IW'(1);
            end else begin
               cell_ctl.op = OP_ROT_R;
               offset_in   = offset_ff - IW'(1);
            end
         end
         // rotate back to the home position
         ST_BACK: begin
            cell_ctl.op = OP_ROT_R;
            offset_in   = offset_ff - IW'(1);
            if (offset_ff == IW'(1)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
            end
         end
         // one full turn of the ring looking for the first handle match
         ST_SCAN: begin
            cell_ctl.op = OP_ROT_L;
            offset_in   = offset_last ? '0 : offset_ff + IW'(1);
            if (scan_hit) begin
               hit_in  = 1'b1;
               mark_in = offset_ff;
            end
            if (offset_last && !(hit_ff || scan_hit)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STS_MISS;
               rsp_found_in  = '0;
            end
         end
         // close the gap at the matched entry
         ST_DROP: begin
            cell_ctl.op   = OP_DROP;
            cell_sel      = CW'(mark_ff);
            count_in      = count_ff - CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = STS_OK;
            rsp_found_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         needs_sort_ff <= 1'b0;
         offset_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         needs_sort_ff <= needs_sort_in;
         offset_ff     <= offset_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      hnd_ff        <= hnd_in;
      first_ff      <= first_in;
      last1_ff      <= last1_in;
      round_ff      <= round_in;
      mark_ff       <= mark_in;
      hit_ff        <= hit_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign cell_count       = count_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_handle = rsp_found_ff;

endmodule

`default_nettype wire

[hw/rtl/sorted_id_table.sv]
// Insert and unused codes answer in the cycle after start, busy stays low.
// Remove: busy for one full turn of the cell ring, plus a drop step on a hit.
// Search: sort rounds when unsorted, then ring moves to each probe and back home.
// One request at a time, taken only while idle; results leave on a one-cycle strobe.
// Reset: clears count, sort flag and sequencer; cell contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_id_table: table of (id, handle) entries in a chain of cells
// Insert appends, search sorts by id when needed and binary-searches,
// remove deletes the first entry with a matching handle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_id_table #(
   parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sit_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [sit_pkg::ID_W-1:0]  req_key_id,
   input  logic [sit_pkg::HND_W-1:0]        req_obj_handle,
   output logic                             rsp_strobe,
   output logic [sit_pkg::STAT_W-1:0]       rsp_status,
   output logic [sit_pkg::HND_W-1:0]        rsp_found_handle
);
   import sit_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   cell_ctl_type           cell_ctl;
   logic [CW-1:0]          cell_sel;
   logic [CW-1:0]          cell_count;
   logic signed [ID_W-1:0] cell_id  [TABLE_DEPTH];
   logic [HND_W-1:0]       cell_hnd [TABLE_DEPTH];
   logic [TABLE_DEPTH:0]   swap_chain;

   assign swap_chain[0] = 1'b0;

   // sequencer
   sit_ctrl #(
      .DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_key_id       (req_key_id),
      .req_obj_handle   (req_obj_handle),
      .head_id          (cell_id[0]),
      .head_hnd         (cell_hnd[0]),
      .cell_ctl         (cell_ctl),
      .cell_sel         (cell_sel),
      .cell_count       (cell_count),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_found_handle (rsp_found_handle)
   );

   // ring of cells, each wired to both neighbors
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      sit_cell #(
         .DEPTH (TABLE_DEPTH),
         .IDX   (k)
      ) u_cell (
         .clock      (clock),
         .cell_ctl   (cell_ctl),
         .cell_sel   (cell_sel),
         .cell_count (cell_count),
         .key_id     (req_key_id),
         .key_hnd    (req_obj_handle),
         .left_id    (cell_id[(k + TABLE_DEPTH - 1) % TABLE_DEPTH]),
         .left_hnd   (cell_hnd[(k + TABLE_DEPTH - 1) % TABLE_DEPTH]),
         .right_id   (cell_id[(k + 1) % TABLE_DEPTH]),
         .right_hnd  (cell_hnd[(k + 1) % TABLE_DEPTH]),
         .swap_in    (swap_chain[k]),
         .id_q       (cell_id[k]),
         .hnd_q      (cell_hnd[k]),
         .swap_out   (swap_chain[k + 1])
      );
   end

endmodule

`default_nettype wire

[hw/rtl/sit_checker.sv]
// ----------------------------------------------------------------------------
// sit_checker: port-level checks of the sorted id table
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [sit_pkg::FUNC_W-1:0]  req_func,
   input logic                        rsp_strobe,
   input logic [sit_pkg::STAT_W-1:0]  rsp_status,
   input logic [sit_pkg::HND_W-1:0]   rsp_found_handle
);
   import sit_pkg::*;

   // a result beat only comes out when the block is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // search and remove keep the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == FN_SEARCH || req_func == FN_REMOVE)) |=> busy)
      else $error("long operation did not go busy");

   // insert and unused codes answer in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func != FN_SEARCH && req_func != FN_REMOVE)
      |=> (rsp_strobe && !busy))
      else $error("short operation gave no result beat");

   // every end of a busy period delivers its result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy ended without a result beat");

   // a handle is only reported on success
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STS_OK) |-> (rsp_found_handle == '0))
      else $error("handle reported on failure");

endmodule

bind sorted_id_table sit_checker u_sit_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_func         (req_func),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_found_handle (rsp_found_handle)
);

`default_nettype wire
